// ===== hdl/otl_pkg.sv =====
package otl_pkg;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_MOVE   = 3'd2,
		OP_REMOVE = 3'd3,
		OP_FIND   = 3'd4,
		OP_GET    = 3'd5,
		OP_SWAP   = 3'd6,
		OP_CLEAR  = 3'd7
	} otl_op_t;

	// Shift action broadcast to every cell of the chain
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_REMOVE,
		ACT_MOVE_UP,
		ACT_MOVE_DOWN,
		ACT_SWAP
	} otl_act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_READ,
		ST_APPLY
	} otl_state_t;

	typedef struct packed {
		logic        [31:0] id;
		logic        [31:0] pri;
		logic signed [31:0] cyc;
	} otl_entry_t;

	localparam int ENTRY_W = $bits(otl_entry_t);

	typedef struct packed {
		otl_act_t   act;
		otl_entry_t data_a;
		otl_entry_t data_b;
	} otl_cmd_t;

	// Per-cell compare results, masked by occupancy
	typedef struct packed {
		logic a;
		logic b;
		logic p;
	} otl_hit_t;

endpackage

// ===== hdl/otl_cell.sv =====
module otl_cell #(
	parameter int CAPACITY = 64,
	parameter int INDEX    = 0
) (
	input  logic                              clk,
	input  otl_pkg::otl_cmd_t                 cmd,
	input  logic [$clog2(CAPACITY)-1:0]       idx_a,
	input  logic [$clog2(CAPACITY)-1:0]       idx_b,
	input  logic [31:0]                       key_id,
	input  logic [31:0]                       key_other,
	input  logic [6:0]                        key_pos,
	input  logic [$clog2(CAPACITY+1)-1:0]     count,
	input  otl_pkg::otl_entry_t               from_left,
	input  otl_pkg::otl_entry_t               from_right,
	output otl_pkg::otl_entry_t               entry,
	output otl_pkg::otl_hit_t                 hit
);
	import otl_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam logic [IW-1:0]   MY_IDX = IW'(INDEX);
	localparam logic [CMPW-1:0] MY_CMP = CMPW'(INDEX);

	otl_entry_t entry_q;
	otl_entry_t entry_d;
	logic       live;

	assign live  = MY_CMP < CMPW'(count);
	assign hit.a = live && (entry_q.id == key_id);
	assign hit.b = live && (entry_q.id == key_other);
	assign hit.p = live && (MY_CMP == CMPW'(key_pos));
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (cmd.act)
			ACT_INSERT: begin
				if (MY_IDX == idx_b) begin
					entry_d = cmd.data_a;
				end else if (MY_IDX > idx_b) begin
					entry_d = from_left;
				end
			end
			ACT_REMOVE: begin
				if (MY_IDX >= idx_a) begin
					entry_d = from_right;
				end
			end
			ACT_MOVE_UP: begin
				if (MY_IDX == idx_b) begin
					entry_d = cmd.data_a;
				end else if (MY_IDX >= idx_a && MY_IDX < idx_b) begin
					entry_d = from_right;
				end
			end
			ACT_MOVE_DOWN: begin
				if (MY_IDX == idx_b) begin
					entry_d = cmd.data_a;
				end else if (MY_IDX > idx_b && MY_IDX <= idx_a) begin
					entry_d = from_left;
				end
			end
			ACT_SWAP: begin
				if (MY_IDX == idx_a) begin
					entry_d = cmd.data_b;
				end else if (MY_IDX == idx_b) begin
					entry_d = cmd.data_a;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== hdl/ordered_task_list.sv =====
// Ordered task list: a row of CAPACITY cells, one task (id, priority,
// signed cycle count) per cell, held in list order. Each operation runs
// through the states in order, and its result then sits in the output
// register: the accepting edge captures the beat, ST_MATCH latches the
// compare of the key ids and the position in every cell at once, ST_READ
// reduces the one-hot hits to an index and the entry they select, and
// ST_APPLY applies the change, where each cell takes its left or right
// neighbor, a broadcast entry, or holds. The apply waits while the
// previous result is still held by out_stall. The next beat can be
// accepted in the cycle after the result is loaded, even while that
// result still waits on out_stall, but no beat is taken before the
// previous one is applied. The one-hot reduction over all cells sets the
// clock in this design. Cells beyond the entry count are never read, so
// no clearing pass follows reset and clear only drops the count.
// entry_count reports the count modulo 128.
module ordered_task_list #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic [6:0]         position,
	input  logic [31:0]        task_id,
	input  logic [31:0]        other_id,
	input  logic [31:0]        task_priority,
	input  logic signed [31:0] task_cycles,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [31:0]        found_id,
	output logic [31:0]        found_priority,
	output logic signed [31:0] found_cycles,
	output logic [6:0]         entry_count
);
	import otl_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;

	// Control state
	otl_state_t state_q;
	otl_state_t state_d;
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	// Captured beat
	otl_op_t            op_q;
	logic [6:0]         pos_q;
	logic [31:0]        id_q;
	logic [31:0]        other_q;
	logic [31:0]        pri_q;
	logic signed [31:0] cyc_q;

	// Match and read results
	logic [CAPACITY-1:0] vec_a_q;
	logic [CAPACITY-1:0] vec_b_q;
	logic [IW-1:0]       idx_a_q;
	logic [IW-1:0]       idx_b_q;
	logic                found_a_q;
	logic                found_b_q;
	otl_entry_t          ent_a_q;
	otl_entry_t          ent_b_q;

	// Result register
	logic               status_q;
	otl_entry_t         res_q;
	logic [CW-1:0]      res_count_q;

	// Chain wiring
	otl_entry_t          cell_ent [CAPACITY];
	otl_hit_t            cell_hit [CAPACITY];
	logic [CAPACITY-1:0] hit_a;
	logic [CAPACITY-1:0] hit_b;
	logic [CAPACITY-1:0] hit_p;
	otl_cmd_t            cmd;
	logic [IW-1:0]       cmd_idx_a;
	logic [IW-1:0]       cmd_idx_b;

	// Combinational control
	logic take;
	logic apply_go;
	logic apply_fire;

	// Reduction
	logic [IW-1:0]      idx_a_c;
	logic [IW-1:0]      idx_b_c;
	logic [ENTRY_W-1:0] ent_a_c;
	logic [ENTRY_W-1:0] ent_b_c;

	// Decision
	logic          fail_c;
	logic          report_c;
	otl_act_t      act_c;
	logic [CW-1:0] count_c;
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] ins_x;
	logic [CMPW-1:0] idx_a_x;

	//--------------------------------------------------------------------
	// Cell chain
	//--------------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int LEFT  = (i == 0) ? 0 : i - 1;
		localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

		otl_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx_a      (cmd_idx_a),
			.idx_b      (cmd_idx_b),
			.key_id     (id_q),
			.key_other  (other_q),
			.key_pos    (pos_q),
			.count      (count_q),
			.from_left  (cell_ent[LEFT]),
			.from_right (cell_ent[RIGHT]),
			.entry      (cell_ent[i]),
			.hit        (cell_hit[i])
		);

		assign hit_a[i] = cell_hit[i].a;
		assign hit_b[i] = cell_hit[i].b;
		assign hit_p[i] = cell_hit[i].p;
	end

	//--------------------------------------------------------------------
	// Sequencer
	//--------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MATCH;
			ST_MATCH: state_d = ST_READ;
			ST_READ:  state_d = ST_APPLY;
			ST_APPLY: if (apply_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		// Output register frees when empty or drained this edge
		apply_go   = !out_valid_q || !out_stall;
		in_stall   = 1'b1;
		apply_fire = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_APPLY: apply_fire = apply_go;
			default: begin
				in_stall   = 1'b1;
				apply_fire = 1'b0;
			end
		endcase
	end

	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply_fire) begin
				count_q     <= count_c;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the beat
	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= otl_op_t'(operation);
			pos_q   <= position;
			id_q    <= task_id;
			other_q <= other_id;
			pri_q   <= task_priority;
			cyc_q   <= task_cycles;
		end
	end

	// Latch the hit vectors; get selects by position instead of id
	always_ff @(posedge clk) begin
		if (state_q == ST_MATCH) begin
			vec_a_q <= (op_q == OP_GET) ? hit_p : hit_a;
			vec_b_q <= hit_b;
		end
	end

	// Reduce one-hot hits to index and entry
	always_comb begin
		idx_a_c = '0;
		idx_b_c = '0;
		ent_a_c = '0;
		ent_b_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			idx_a_c = idx_a_c | ({IW{vec_a_q[i]}} & IW'(i));
			idx_b_c = idx_b_c | ({IW{vec_b_q[i]}} & IW'(i));
			ent_a_c = ent_a_c | ({ENTRY_W{vec_a_q[i]}} & cell_ent[i]);
			ent_b_c = ent_b_c | ({ENTRY_W{vec_b_q[i]}} & cell_ent[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			idx_a_q   <= idx_a_c;
			idx_b_q   <= idx_b_c;
			found_a_q <= |vec_a_q;
			found_b_q <= |vec_b_q;
			ent_a_q   <= otl_entry_t'(ent_a_c);
			ent_b_q   <= otl_entry_t'(ent_b_c);
		end
	end

	//--------------------------------------------------------------------
	// Decide pass or fail and the shift to apply
	//--------------------------------------------------------------------
	assign cnt_x   = CMPW'(count_q);
	assign pos_x   = CMPW'(pos_q);
	assign idx_a_x = CMPW'(idx_a_q);
	assign ins_x   = (op_q == OP_APPEND) ? cnt_x : pos_x;

	always_comb begin
		fail_c    = 1'b0;
		report_c  = 1'b0;
		act_c     = ACT_NONE;
		count_c   = count_q;
		cmd_idx_a = idx_a_q;
		cmd_idx_b = idx_b_q;
		case (op_q)
			OP_APPEND, OP_INSERT: begin
				cmd_idx_b = ins_x[IW-1:0];
				if (found_a_q || ins_x > cnt_x || cnt_x >= CMPW'(CAPACITY)) begin
					fail_c = 1'b1;
				end else begin
					act_c   = ACT_INSERT;
					count_c = count_q + CW'(1);
				end
			end
			OP_MOVE: begin
				cmd_idx_b = pos_x[IW-1:0];
				if (pos_x >= cnt_x || !found_a_q) begin
					fail_c = 1'b1;
				end else if (idx_a_x < pos_x) begin
					act_c = ACT_MOVE_UP;
				end else if (idx_a_x > pos_x) begin
					act_c = ACT_MOVE_DOWN;
				end
			end
			OP_REMOVE, OP_FIND, OP_GET: begin
				if (!found_a_q) begin
					fail_c = 1'b1;
				end else begin
					report_c = 1'b1;
					if (op_q == OP_REMOVE) begin
						act_c   = ACT_REMOVE;
						count_c = count_q - CW'(1);
					end
				end
			end
			OP_SWAP: begin
				if (id_q == other_q || !found_a_q || !found_b_q) begin
					fail_c = 1'b1;
				end else begin
					act_c = ACT_SWAP;
				end
			end
			OP_CLEAR: count_c = '0;
			default:  count_c = count_q;
		endcase
	end

	// Broadcast to the chain only on the applying edge
	always_comb begin
		cmd.act        = apply_fire ? act_c : ACT_NONE;
		cmd.data_b     = ent_b_q;
		cmd.data_a     = ent_a_q;
		// Insert carries the new task; move and swap carry stored entries
		if (op_q == OP_APPEND || op_q == OP_INSERT) begin
			cmd.data_a.id  = id_q;
			cmd.data_a.pri = pri_q;
			cmd.data_a.cyc = cyc_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (apply_fire) begin
			status_q    <= fail_c;
			res_q       <= report_c ? ent_a_q : '0;
			res_count_q <= count_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_id       = res_q.id;
	assign found_priority = res_q.pri;
	assign found_cycles   = res_q.cyc;

	logic [CMPW-1:0] res_count_x;
	assign res_count_x = CMPW'(res_count_q);
	assign entry_count = res_count_x[6:0];

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import otl_pkg::*;

	localparam int CAP         = 64;
	localparam int CYCLE_LIMIT = 400000;
	// Allow a wide margin when draining
	localparam int TAIL_CYCLES = 16;

	// One operation beat as the sender presents it
	typedef struct packed {
		otl_op_t            op;
		logic [6:0]         pos;
		logic [31:0]        id;
		logic [31:0]        other;
		logic [31:0]        pri;
		logic signed [31:0] cyc;
	} op_beat_t;

	// One result beat as the block should return it
	typedef struct packed {
		logic               fail;
		logic [31:0]        id;
		logic [31:0]        pri;
		logic signed [31:0] cyc;
		logic [6:0]         count;
	} op_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         operation = OP_CLEAR;
	logic [6:0]         position = '0;
	logic [31:0]        task_id = '0;
	logic [31:0]        other_id = '0;
	logic [31:0]        task_priority = '0;
	logic signed [31:0] task_cycles = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               status;
	logic [31:0]        found_id;
	logic [31:0]        found_priority;
	logic signed [31:0] found_cycles;
	logic [6:0]         entry_count;

	// Shadow copy of the task list, kept in list order
	logic [31:0]        list_id [CAP];
	logic [31:0]        list_pri [CAP];
	logic signed [31:0] list_cyc [CAP];
	int                 list_len = 0;

	// Results predicted at acceptance, oldest first
	op_result_t pending_results [$];

	int error_count   = 0;
	int ops_total     = 0;
	int ops_rejected  = 0;
	int peak_len      = 0;
	int results_seen  = 0;
	int held_cycles   = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int hold_left     = 0;
	int fill_goal     = CAP;

	ordered_task_list #(
		.CAPACITY(CAP)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.position      (position),
		.task_id       (task_id),
		.other_id      (other_id),
		.task_priority (task_priority),
		.task_cycles   (task_cycles),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_id      (found_id),
		.found_priority(found_priority),
		.found_cycles  (found_cycles),
		.entry_count   (entry_count)
	);

	always #1 clk = ~clk;

	// Bound the run; a hung handshake ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles, %0d results pending",
				cycle_count, pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stall per cycle, or a long hold-off when a test asks for one.
	// The hold is counted here so the sender keeps pushing while the block backs up.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic flag_error(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// Compare every accepted result beat against the oldest prediction.
	// Values are read before this edge's updates land, so ordering is safe.
	always @(posedge clk) begin : check_results
		op_result_t want;
		if (arst_n && in_valid && in_stall)
			held_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_error("result beat with nothing pending");
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (status !== want.fail)
					flag_error($sformatf("result %0d status got %b want %b",
						results_seen, status, want.fail));
				if (found_id !== want.id)
					flag_error($sformatf("result %0d found_id got %h want %h",
						results_seen, found_id, want.id));
				if (found_priority !== want.pri)
					flag_error($sformatf("result %0d found_priority got %h want %h",
						results_seen, found_priority, want.pri));
				if (found_cycles !== want.cyc)
					flag_error($sformatf("result %0d found_cycles got %0d want %0d",
						results_seen, found_cycles, want.cyc));
				if (entry_count !== want.count)
					flag_error($sformatf("result %0d entry_count got %0d want %0d",
						results_seen, entry_count, want.count));
			end
		end
	end

	// ---- list predictor ----

	// Position of key in the list, or list_len when absent
	function automatic int index_of(input logic [31:0] key);
		for (int i = 0; i < list_len; i++)
			if (list_id[i] == key)
				return i;
		return list_len;
	endfunction

	// Shift the tail down one place and drop the entry into the gap
	function automatic void open_slot(input int at, input logic [31:0] id,
			input logic [31:0] pri, input logic signed [31:0] cyc);
		for (int i = list_len; i > at; i--) begin
			list_id[i]  = list_id[i - 1];
			list_pri[i] = list_pri[i - 1];
			list_cyc[i] = list_cyc[i - 1];
		end
		list_id[at]  = id;
		list_pri[at] = pri;
		list_cyc[at] = cyc;
		list_len++;
	endfunction

	// Pull the tail up one place over the entry at index at
	function automatic void close_slot(input int at);
		for (int i = at; i + 1 < list_len; i++) begin
			list_id[i]  = list_id[i + 1];
			list_pri[i] = list_pri[i + 1];
			list_cyc[i] = list_cyc[i + 1];
		end
		list_len--;
	endfunction

	// Apply one accepted beat to the shadow list and queue its result
	task automatic predict_op(input op_beat_t b);
		op_result_t         res;
		int                 a;
		int                 c;
		logic [31:0]        keep_pri;
		logic signed [31:0] keep_cyc;
		res = '0;
		case (b.op)
			OP_APPEND, OP_INSERT: begin
				a = (b.op == OP_APPEND) ? list_len : int'(b.pos);
				// duplicate id, index past the end, or no room left
				if (index_of(b.id) < list_len || a > list_len || list_len >= CAP)
					res.fail = 1'b1;
				else
					open_slot(a, b.id, b.pri, b.cyc);
			end
			OP_MOVE: begin
				a = index_of(b.id);
				if (int'(b.pos) >= list_len || a >= list_len) begin
					res.fail = 1'b1;
				end else begin
					// take it out, then put it back so it lands at pos
					keep_pri = list_pri[a];
					keep_cyc = list_cyc[a];
					close_slot(a);
					open_slot(int'(b.pos), b.id, keep_pri, keep_cyc);
				end
			end
			OP_REMOVE, OP_FIND, OP_GET: begin
				a = (b.op == OP_GET) ? int'(b.pos) : index_of(b.id);
				if (a >= list_len) begin
					res.fail = 1'b1;
				end else begin
					res.id  = list_id[a];
					res.pri = list_pri[a];
					res.cyc = list_cyc[a];
					if (b.op == OP_REMOVE)
						close_slot(a);
				end
			end
			OP_SWAP: begin
				a = index_of(b.id);
				c = index_of(b.other);
				if (b.id == b.other || a >= list_len || c >= list_len) begin
					res.fail = 1'b1;
				end else begin
					{list_id[a], list_id[c]}   = {list_id[c], list_id[a]};
					{list_pri[a], list_pri[c]} = {list_pri[c], list_pri[a]};
					{list_cyc[a], list_cyc[c]} = {list_cyc[c], list_cyc[a]};
				end
			end
			OP_CLEAR: begin
				list_len = 0;
			end
		endcase
		res.count = 7'(list_len);
		pending_results.push_back(res);
		ops_total++;
		if (res.fail)
			ops_rejected++;
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	// ---- stimulus helpers ----

	function automatic op_beat_t mk(input otl_op_t op, input int pos,
			input logic [31:0] id, input logic [31:0] other,
			input logic [31:0] pri, input logic signed [31:0] cyc);
		op_beat_t b;
		b.op    = op;
		b.pos   = 7'(pos);
		b.id    = id;
		b.other = other;
		b.pri   = pri;
		b.cyc   = cyc;
		return b;
	endfunction

	// An id already in the list at hit_pct percent; otherwise fresh, small or near all-ones
	function automatic logic [31:0] pick_id(input int hit_pct);
		logic [31:0] v;
		v = $urandom();
		if (list_len > 0 && $urandom_range(0, 99) < hit_pct)
			v = list_id[$urandom_range(0, list_len - 1)];
		else if ($urandom_range(0, 3) == 0)
			v = $urandom_range(0, 15);
		else if ($urandom_range(0, 7) == 0)
			v = 32'hFFFF_FFFF - $urandom_range(0, 3);
		return v;
	endfunction

	// Mostly an index within span; now and then anything the field holds
	function automatic logic [6:0] pick_pos(input int span);
		if (span == 0 || $urandom_range(0, 9) == 0)
			return 7'($urandom_range(0, 127));
		return 7'($urandom_range(0, span - 1));
	endfunction

	// Well-formed traffic with random content; the mix leans toward growth
	// until the list reaches fill_goal, then holds roughly level
	function automatic op_beat_t random_beat();
		op_beat_t b;
		int       r;
		int       add_pct;
		r       = $urandom_range(0, 99);
		add_pct = (list_len < fill_goal) ? 45 : 18;
		b = mk(OP_FIND, $urandom_range(0, 127), pick_id(80), pick_id(80),
			$urandom(), $urandom());
		case ($urandom_range(0, 7))
			0: b.cyc = 32'sh8000_0000;
			1: b.cyc = 32'sh7FFF_FFFF;
			2: b.pri = '1;
			3: b.pri = '0;
			default: ;
		endcase
		if (r < 1 && fill_goal != CAP) begin
			b.op = OP_CLEAR;
		end else if (r < 1 + add_pct) begin
			b.op  = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
			b.id  = pick_id(12);
			b.pos = pick_pos(list_len + 1);
		end else if (r < 20 + add_pct) begin
			b.op = OP_REMOVE;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					b.op  = OP_MOVE;
					b.pos = pick_pos(list_len);
				end
				1: b.op = OP_FIND;
				2: begin
					b.op  = OP_GET;
					b.pos = pick_pos(list_len);
				end
				default: begin
					b.op = OP_SWAP;
					if ($urandom_range(0, 11) == 0)
						b.other = b.id;
				end
			endcase
		end
		return b;
	endfunction

	// Offer one beat, idling first at the sender's rate; hold the payload
	// until the block takes it, then predict its result
	task automatic send_op(input op_beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= b.op;
		position      <= b.pos;
		task_id       <= b.id;
		other_id      <= b.other;
		task_priority <= b.pri;
		task_cycles   <= b.cyc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_op(b);
	endtask

	// Drop valid and pause until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ---- tests ----

	// Field extremes, every operation, and each error path but the full-list one on a short list
	task automatic test_directed_ops();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_op(mk(OP_CLEAR,  0,  32'h0, 32'h0, 32'h0, 32'sh0));         // clear when empty
		send_op(mk(OP_FIND,   0,  32'h5, 32'h0, 32'h0, 32'sh0));         // absent, empty list
		send_op(mk(OP_GET,    0,  32'h0, 32'h0, 32'h0, 32'sh0));         // index on empty list
		send_op(mk(OP_APPEND, 0,  32'h0, 32'h0, 32'h0, 32'sh8000_0000));
		send_op(mk(OP_APPEND, 0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'sh7FFF_FFFF));
		send_op(mk(OP_APPEND, 0,  32'h0, 32'h0, 32'h1, 32'sh1));         // duplicate id
		send_op(mk(OP_INSERT, 0,  32'h1234_5678, 32'h0, 32'h55, -32'sd1));
		send_op(mk(OP_INSERT, 3,  32'hA5A5_A5A5, 32'h0, 32'h8000_0000, 32'sd7));
		send_op(mk(OP_INSERT, 6,  32'h6, 32'h0, 32'h6, 32'sd6));         // past the end
		send_op(mk(OP_INSERT, 127, 32'h7, 32'h0, 32'h7, 32'sd7));        // position all ones
		send_op(mk(OP_INSERT, 1,  32'hFFFF_FFFF, 32'h0, 32'h9, 32'sd9)); // duplicate id
		send_op(mk(OP_MOVE,   0,  32'hA5A5_A5A5, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_MOVE,   3,  32'h1234_5678, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_MOVE,   4,  32'h0, 32'h0, 32'h0, 32'sh0));         // index == count
		send_op(mk(OP_MOVE,   1,  32'h77, 32'h0, 32'h0, 32'sh0));        // absent id
		send_op(mk(OP_GET,    0,  32'h0, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_GET,    3,  32'h0, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_GET,    4,  32'h0, 32'h0, 32'h0, 32'sh0));         // index == count
		send_op(mk(OP_FIND,   0,  32'hFFFF_FFFF, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_FIND,   0,  32'h1, 32'h0, 32'h0, 32'sh0));         // absent id
		send_op(mk(OP_SWAP,   0,  32'h0, 32'hA5A5_A5A5, 32'h0, 32'sh0));
		send_op(mk(OP_SWAP,   0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'sh0)); // same id
		send_op(mk(OP_SWAP,   0,  32'h0, 32'h99, 32'h0, 32'sh0));        // second id absent
		send_op(mk(OP_REMOVE, 0,  32'h1234_5678, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_REMOVE, 0,  32'h1234_5678, 32'h0, 32'h0, 32'sh0)); // already gone
		send_op(mk(OP_CLEAR,  0,  32'h0, 32'h0, 32'h0, 32'sh0));
		drain_results();
	endtask

	// Fill to capacity, hit the full-table rejects, work the last index, clear
	task automatic test_full_table();
		logic [31:0] base;
		int          i;
		send_idle_pct = 20;
		stall_pct     = 20;
		base          = $urandom();
		for (i = 0; i < CAP; i++) begin
			if (i % 3 == 0)
				send_op(mk(OP_INSERT, $urandom_range(0, list_len), base + 32'(i * 7919),
					32'h0, $urandom(), $urandom()));
			else
				send_op(mk(OP_APPEND, 0, base + 32'(i * 7919), 32'h0, $urandom(), $urandom()));
		end
		send_op(mk(OP_APPEND, 0, base - 32'd1, 32'h0, 32'h1, 32'sd1));   // full
		send_op(mk(OP_INSERT, 0, base - 32'd2, 32'h0, 32'h2, 32'sd2));   // full
		send_op(mk(OP_INSERT, 5, base, 32'h0, 32'h3, 32'sd3));           // full and duplicate
		send_op(mk(OP_GET, CAP - 1, 32'h0, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_GET, CAP, 32'h0, 32'h0, 32'h0, 32'sh0));           // one past the end
		send_op(mk(OP_MOVE, CAP - 1, list_id[0], 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_MOVE, 0, list_id[CAP - 1], 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_SWAP, 0, list_id[0], list_id[CAP - 1], 32'h0, 32'sh0));
		send_op(mk(OP_FIND, 0, list_id[CAP / 2], 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_REMOVE, 0, list_id[CAP - 1], 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_INSERT, CAP - 1, base - 32'd4, 32'h0, 32'hFFFF_FFFF,
			32'sh8000_0000));                                             // refill last slot
		send_op(mk(OP_GET, CAP - 1, 32'h0, 32'h0, 32'h0, 32'sh0));
		send_op(mk(OP_CLEAR, 0, 32'h0, 32'h0, 32'h0, 32'sh0));
		drain_results();
	endtask

	// Random traffic at one sender idle rate and one receiver stall rate
	task automatic test_random_traffic(input int n, input int idle_pct, input int hold_pct);
		int i;
		send_idle_pct = idle_pct;
		stall_pct     = hold_pct;
		for (i = 0; i < n; i++) begin
			// retarget the list size now and then so short and long lists both occur
			if (i % 100 == 0) begin
				case ($urandom_range(0, 3))
					0: fill_goal = 4;
					1: fill_goal = 16;
					2: fill_goal = 40;
					default: fill_goal = CAP;
				endcase
			end
			send_op(random_beat());
		end
		drain_results();
	endtask

	// Hold the output off for a long stretch while beats keep coming, so the
	// block fills up and stalls its input; then pause until it drains
	task automatic test_output_holdoff();
		int i;
		send_idle_pct = 0;
		stall_pct     = 0;
		fill_goal     = 16;
		hold_req      = 300;
		for (i = 0; i < 40; i++)
			send_op(random_beat());
		drain_results();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_full_table();
		test_random_traffic(400, 0, 0);
		test_random_traffic(400, 45, 0);
		test_random_traffic(400, 0, 45);
		test_output_holdoff();
		test_random_traffic(400, 32, 32);

		// nothing pending; let any stray beat surface before judging
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d list operations (%0d rejected), list grew to %0d entries",
			ops_total, ops_rejected, peak_len);
		$display("compared %0d results; input backpressured for %0d cycles",
			results_seen, held_cycles);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
